[sv/trpp_pkg.sv]
// ----------------------------------------------------------------------------
// TLS record padding planner package
// Register indexes, strategy codes, item kinds, reset values and fixed protocol constants.
// ----------------------------------------------------------------------------
`default_nettype none

package trpp_pkg;

  // Configuration register indexes, in register-file order.
  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_APP_DATA_ONLY = 3'd1,
    REG_STRATEGY      = 3'd2,
    REG_MAX_SIZE      = 3'd3,
    REG_BLOCK_SIZE    = 3'd4,
    REG_MIN_EXTRA     = 3'd5,
    REG_MAX_EXTRA     = 3'd6
  } cfg_reg_t;

  // Padding strategy codes; any other code means no padding.
  localparam logic [2:0] STRAT_POW2   = 3'd0;
  localparam logic [2:0] STRAT_BLOCK  = 3'd1;
  localparam logic [2:0] STRAT_RANDOM = 3'd2;
  localparam logic [2:0] STRAT_CONST  = 3'd3;

  // Item kinds carried in the input tuser bit.
  localparam logic KIND_SEALED    = 1'b0;
  localparam logic KIND_PLAINTEXT = 1'b1;

  // Record framing constants.
  localparam logic [7:0]  APP_DATA_TYPE = 8'h17;
  localparam logic [16:0] HEADER_BYTES  = 17'd5;

  // Register reset values.
  localparam logic [2:0]  RST_STRATEGY   = STRAT_POW2;
  localparam logic [15:0] RST_MAX_SIZE   = 16'd16384;
  localparam logic [15:0] RST_BLOCK_SIZE = 16'd256;
  localparam logic [15:0] RST_MIN_EXTRA  = 16'd0;
  localparam logic [15:0] RST_MAX_EXTRA  = 16'd255;

endpackage

`default_nettype wire

[sv/tls_record_padding_planner_unit.sv]
// ----------------------------------------------------------------------------
// TLS record padding planner
// Decides the padded length of each TLS record and keeps padding statistics.
// ----------------------------------------------------------------------------
// Usage:
//   Records enter on the s_* stream channel, one transaction per record, and
//   one result per record leaves on the m_* channel. The user is to write the
//   configuration registers through the cfg_* channel only while the block is
//   idle; the block itself does not enforce this. cfg_ready is always high
//   and indexes beyond the register list are ignored. Each record is worked
//   by a small sequencer around one iterative unit: the power-of-two search
//   shifts once per cycle (up to 17 steps) and the block alignment takes a
//   remainder one bit per cycle (17 steps). s_tready is low while a record
//   is being worked and rises in the same cycle as m_tvalid, so a new record
//   is accepted only after the sequencer is done with the previous one. The
//   result register lets a new record be accepted while the previous result
//   still waits; if the receiver stalls past that, the sequencer holds in its
//   final step until the result register is free. Synchronous reset restores
//   all configuration registers to their reset values and clears the four
//   statistics counters.
// ----------------------------------------------------------------------------
`default_nettype none

module tls_record_padding_planner_unit #(
  parameter int unsigned RECORD_LIMIT = 16384
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Configuration write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  // Record input channel.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tdata: body_len[15:0], total_len[32:16], type_byte[40:33],
  //          random_extra[56:41], zero fill[63:57]
  input  wire logic [63:0]  s_tdata,
  // s_tuser: func[0]
  input  wire logic         s_tuser,
  // Result output channel.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata: new_len[16:0], pad_bytes[32:17], processed_count[64:33],
  //          skipped_count[96:65], padded_count[128:97],
  //          padding_total[160:129], zero fill[167:161]
  output logic [167:0]      m_tdata,
  // m_tuser: status[0]
  output logic              m_tuser
);

  localparam int unsigned LEN_W = 17;
  localparam logic [16:0] LIMIT = 17'(RECORD_LIMIT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_EXT,
    S_ITER,
    S_TGT,
    S_CLAMP,
    S_FIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic        enable;
  logic        app_data_only;
  logic [2:0]  strategy;
  logic [15:0] max_size;
  logic [15:0] block_size;
  logic [15:0] min_extra;
  logic [15:0] max_extra;

  // Captured record and working registers.
  logic              kind;
  logic [15:0]       plen;
  logic [16:0]       total;
  logic [7:0]        ctype;
  logic [15:0]       draw;
  logic [LEN_W-1:0]  len;
  logic              skip;
  logic [15:0]       extra;
  logic [16:0]       p;
  logic [15:0]       rem;
  logic [LEN_W-1:0]  dsh;
  logic [4:0]        cnt;
  logic [17:0]       raw;
  logic [16:0]       t;

  // Statistics counters and result registers.
  logic [31:0] processed_ctr;
  logic [31:0] skipped_ctr;
  logic [31:0] padded_ctr;
  logic [31:0] padding_sum;
  logic        out_status;
  logic [16:0] out_new_len;
  logic [15:0] out_pad;

  logic s_xfer;
  logic m_xfer;
  logic iterate;
  logic res_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  assign m_xfer    = m_tvalid && m_tready;

  // The result register is loaded once the final step finds it free.
  assign res_load  = (state == S_FIN) && (!m_tvalid || m_tready);

  // The shared unit runs only for the power-of-two and aligned block cases.
  assign iterate = (strategy == trpp_pkg::STRAT_POW2) ||
                   ((strategy == trpp_pkg::STRAT_BLOCK) && (block_size != 16'd0));

  // Sealed-record framing and policy checks.
  logic skip_in;
  always_comb begin
    skip_in = 1'b0;
    if ((kind == trpp_pkg::KIND_SEALED) &&
        ((total < trpp_pkg::HEADER_BYTES) ||
         (total != ({1'b0, plen} + trpp_pkg::HEADER_BYTES)))) begin
      skip_in = 1'b1;
    end
    if (!enable) begin
      skip_in = 1'b1;
    end
    if (app_data_only && (ctype != trpp_pkg::APP_DATA_TYPE)) begin
      skip_in = 1'b1;
    end
  end

  // One restoring remainder step.
  logic [16:0] rem_sh;
  logic [15:0] rem_next;
  always_comb begin
    rem_sh = {rem, dsh[LEN_W-1]};
    if (rem_sh >= {1'b0, block_size}) begin
      rem_next = 16'(rem_sh - {1'b0, block_size});
    end else begin
      rem_next = rem_sh[15:0];
    end
  end

  // Unclamped target size for each strategy.
  logic [17:0] raw_next;
  always_comb begin
    case (strategy)
      trpp_pkg::STRAT_POW2: begin
        raw_next = {1'b0, p};
      end
      trpp_pkg::STRAT_BLOCK: begin
        if ((block_size == 16'd0) || (rem == 16'd0)) begin
          raw_next = {1'b0, len};
        end else begin
          raw_next = {1'b0, len} - {2'b00, rem} + {2'b00, block_size};
        end
      end
      trpp_pkg::STRAT_RANDOM: begin
        raw_next = {1'b0, len} + {2'b00, extra};
      end
      trpp_pkg::STRAT_CONST: begin
        raw_next = {2'b00, max_size};
      end
      default: begin
        raw_next = {1'b0, len};
      end
    endcase
  end

  // Clamp to the maximum size unless no strategy applies.
  logic [16:0] t_next;
  always_comb begin
    if (strategy > trpp_pkg::STRAT_CONST) begin
      t_next = raw[16:0];
    end else if (raw < {2'b00, max_size}) begin
      t_next = raw[16:0];
    end else begin
      t_next = {1'b0, max_size};
    end
  end

  // Final decision: sealed records must grow and stay within the limit.
  logic        fail_seal;
  logic        grow;
  logic        skip_final;
  logic [16:0] new_len_next;
  logic [15:0] pad_next;
  always_comb begin
    fail_seal = (kind == trpp_pkg::KIND_SEALED) &&
                ((t <= {1'b0, plen}) || (t > LIMIT));
    grow       = (t > len);
    skip_final = skip || fail_seal;
    if (skip_final) begin
      new_len_next = {1'b0, plen};
      pad_next     = 16'd0;
    end else if (kind == trpp_pkg::KIND_PLAINTEXT) begin
      new_len_next = grow ? t : len;
      pad_next     = grow ? 16'(t - len) : 16'd0;
    end else begin
      new_len_next = t;
      pad_next     = 16'(t - {1'b0, plen});
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      app_data_only <= 1'b1;
      strategy      <= trpp_pkg::RST_STRATEGY;
      max_size      <= trpp_pkg::RST_MAX_SIZE;
      block_size    <= trpp_pkg::RST_BLOCK_SIZE;
      min_extra     <= trpp_pkg::RST_MIN_EXTRA;
      max_extra     <= trpp_pkg::RST_MAX_EXTRA;
    end else if (cfg_valid && cfg_ready) begin
      case (trpp_pkg::cfg_reg_t'(cfg_index))
        trpp_pkg::REG_ENABLE:        enable        <= cfg_data[0];
        trpp_pkg::REG_APP_DATA_ONLY: app_data_only <= cfg_data[0];
        trpp_pkg::REG_STRATEGY:      strategy      <= cfg_data[2:0];
        trpp_pkg::REG_MAX_SIZE:      max_size      <= cfg_data;
        trpp_pkg::REG_BLOCK_SIZE:    block_size    <= cfg_data;
        trpp_pkg::REG_MIN_EXTRA:     min_extra     <= cfg_data;
        trpp_pkg::REG_MAX_EXTRA:     max_extra     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, working registers, counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      processed_ctr <= 32'd0;
      skipped_ctr   <= 32'd0;
      padded_ctr    <= 32'd0;
      padding_sum   <= 32'd0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_xfer) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_xfer) begin
            kind  <= s_tuser;
            plen  <= s_tdata[15:0];
            total <= s_tdata[32:16];
            ctype <= s_tdata[40:33];
            draw  <= s_tdata[56:41];
            len   <= s_tuser ? ({1'b0, s_tdata[15:0]} + 17'd1) : {1'b0, s_tdata[15:0]};
            state <= S_PREP;
          end
        end
        S_PREP: begin
          skip  <= skip_in;
          extra <= (draw > max_extra) ? max_extra : draw;
          state <= S_EXT;
        end
        S_EXT: begin
          if (extra < min_extra) begin
            extra <= min_extra;
          end
          p     <= 17'd1;
          rem   <= 16'd0;
          dsh   <= len;
          cnt   <= 5'(LEN_W - 1);
          state <= iterate ? S_ITER : S_TGT;
        end
        S_ITER: begin
          if (strategy == trpp_pkg::STRAT_POW2) begin
            if (p < len) begin
              p <= {p[15:0], 1'b0};
            end else begin
              state <= S_TGT;
            end
          end else begin
            rem <= rem_next;
            dsh <= {dsh[LEN_W-2:0], 1'b0};
            if (cnt == 5'd0) begin
              state <= S_TGT;
            end else begin
              cnt <= cnt - 5'd1;
            end
          end
        end
        S_TGT: begin
          raw   <= raw_next;
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          t     <= t_next;
          state <= S_FIN;
        end
        S_FIN: begin
          if (res_load) begin
            out_status    <= skip_final;
            out_new_len   <= new_len_next;
            out_pad       <= pad_next;
            processed_ctr <= processed_ctr + 32'd1;
            if (skip_final) begin
              skipped_ctr <= skipped_ctr + 32'd1;
            end else begin
              padded_ctr  <= padded_ctr + 32'd1;
              padding_sum <= padding_sum + {16'd0, pad_next};
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Counters change only when a result is loaded, so they feed the output.
  assign m_tuser = out_status;
  assign m_tdata = {7'd0, padding_sum, padded_ctr, skipped_ctr, processed_ctr,
                    out_pad, out_new_len};

  // Every record is counted exactly once, as skipped or as padded.
  a_count_balance: assert property (@(posedge clk) disable iff (rst)
    processed_ctr == (skipped_ctr + padded_ctr))
    else $error("processed count differs from skipped plus padded");

  // An accepted record keeps the input closed for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> !s_tready)
    else $error("input reopened right after acceptance");

  // A skipped result never carries padding.
  a_skip_no_pad: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_pad == 16'd0))
    else $error("skipped record reports padding bytes");

  // The iterative unit runs only for the power-of-two or aligned block cases.
  a_iter_strategy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER) |-> iterate)
    else $error("iterative unit running for a strategy that does not use it");

endmodule

`default_nettype wire

[sim/tb_tls_record_padding_planner_unit.sv]
// ----------------------------------------------------------------------------
// TLS record padding planner testbench
// Drives records through the stream input under a series of register
// settings and checks every result against a behavioral plan of each record.
// Both stream sides idle in random bursts, except in the final phase.
// ----------------------------------------------------------------------------
module tb_tls_record_padding_planner_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RECORD_LIMIT = 16384;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 30;
  // Register index past the end of the register file; the block ignores it.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  // Strategy codes that select no padding.
  localparam logic [2:0] STRAT_NONE  = 3'd4;
  localparam logic [2:0] STRAT_SPARE = 3'd7;

  typedef struct packed {
    logic        func;
    logic [15:0] body_len;
    logic [16:0] total_len;
    logic [7:0]  type_byte;
    logic [15:0] random_extra;
  } record_t;

  typedef struct packed {
    logic        status;
    logic [16:0] new_len;
    logic [15:0] pad_bytes;
    logic [31:0] processed_count;
    logic [31:0] skipped_count;
    logic [31:0] padded_count;
    logic [31:0] padding_total;
  } plan_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [15:0]   cfg_data = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [63:0]   s_tdata = '0;
  logic          s_tuser = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [167:0]  m_tdata;
  logic          m_tuser;

  // Shadow copy of the register file.
  logic          sh_enable;
  logic          sh_app_only;
  logic [2:0]    sh_strategy;
  logic [15:0]   sh_max_size;
  logic [15:0]   sh_block_size;
  logic [15:0]   sh_min_extra;
  logic [15:0]   sh_max_extra;

  // Shadow statistics counters.
  logic [31:0]   n_processed;
  logic [31:0]   n_skipped;
  logic [31:0]   n_padded;
  logic [31:0]   pad_sum;

  record_t       record_q[$];
  plan_t         planned_q[$];
  record_t       in_flight;
  plan_t         oldest_plan;
  int            src_gap = 0;
  int            sink_gap = 0;
  bit            calm = 1'b0;
  bit            src_busy;
  int            err_count = 0;

  tls_record_padding_planner_unit #(
    .RECORD_LIMIT(RECORD_LIMIT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state after reset.
  initial begin
    sh_enable     = 1'b1;
    sh_app_only   = 1'b1;
    sh_strategy   = trpp_pkg::RST_STRATEGY;
    sh_max_size   = trpp_pkg::RST_MAX_SIZE;
    sh_block_size = trpp_pkg::RST_BLOCK_SIZE;
    sh_min_extra  = trpp_pkg::RST_MIN_EXTRA;
    sh_max_extra  = trpp_pkg::RST_MAX_EXTRA;
    n_processed   = '0;
    n_skipped     = '0;
    n_padded      = '0;
    pad_sum       = '0;
  end

  // Mirror one accepted register write into the shadow copy.
  function automatic void note_reg_write(logic [2:0] idx, logic [15:0] val);
    case (idx)
      trpp_pkg::REG_ENABLE:        sh_enable     = val[0];
      trpp_pkg::REG_APP_DATA_ONLY: sh_app_only   = val[0];
      trpp_pkg::REG_STRATEGY:      sh_strategy   = val[2:0];
      trpp_pkg::REG_MAX_SIZE:      sh_max_size   = val;
      trpp_pkg::REG_BLOCK_SIZE:    sh_block_size = val;
      trpp_pkg::REG_MIN_EXTRA:     sh_min_extra  = val;
      trpp_pkg::REG_MAX_EXTRA:     sh_max_extra  = val;
      default: ;
    endcase
  endfunction

  function automatic int unsigned fit_max(int unsigned v);
    return (v < sh_max_size) ? v : sh_max_size;
  endfunction

  // Padded size of a record of len bytes under the current strategy.
  function automatic int unsigned padded_target(int unsigned len, int unsigned draw);
    int unsigned v;
    int unsigned blk;
    int unsigned extra;
    blk = sh_block_size;
    case (sh_strategy)
      trpp_pkg::STRAT_POW2: begin
        v = 1;
        while (v < len) v = v << 1;
        return fit_max(v);
      end
      trpp_pkg::STRAT_BLOCK: begin
        if (blk == 0) return fit_max(len);
        return fit_max(((len + blk - 1) / blk) * blk);
      end
      trpp_pkg::STRAT_RANDOM: begin
        extra = draw;
        if (extra > sh_max_extra) extra = sh_max_extra;
        if (extra < sh_min_extra) extra = sh_min_extra;
        return fit_max(len + extra);
      end
      trpp_pkg::STRAT_CONST: return sh_max_size;
      default: return len;
    endcase
  endfunction

  // Plan one accepted record and advance the shadow counters.
  function automatic plan_t plan_record(record_t r);
    plan_t       p;
    int unsigned plen;
    int unsigned total;
    int unsigned t;
    int unsigned nl;
    int unsigned pad;
    bit          skip;
    plen  = r.body_len;
    total = r.total_len;
    skip  = 1'b0;
    nl    = plen;
    pad   = 0;
    n_processed = n_processed + 1;
    if (r.func == trpp_pkg::KIND_SEALED &&
        (total < trpp_pkg::HEADER_BYTES || total != plen + trpp_pkg::HEADER_BYTES))
      skip = 1'b1;
    if (!sh_enable) skip = 1'b1;
    if (sh_app_only && r.type_byte != trpp_pkg::APP_DATA_TYPE) skip = 1'b1;
    if (!skip) begin
      if (r.func == trpp_pkg::KIND_PLAINTEXT) begin
        // The type byte always goes in; padding only where the target leaves room.
        t  = padded_target(plen + 1, r.random_extra);
        nl = plen + 1;
        if (t > plen + 1) begin
          pad = t - plen - 1;
          nl  = t;
        end
      end else begin
        t = padded_target(plen, r.random_extra);
        if (t <= plen || t > RECORD_LIMIT) begin
          skip = 1'b1;
        end else begin
          pad = t - plen;
          nl  = t;
        end
      end
    end
    if (skip) begin
      nl  = plen;
      pad = 0;
      n_skipped = n_skipped + 1;
    end else begin
      n_padded = n_padded + 1;
      pad_sum  = pad_sum + pad;
    end
    p.status          = skip;
    p.new_len         = nl[16:0];
    p.pad_bytes       = pad[15:0];
    p.processed_count = n_processed;
    p.skipped_count   = n_skipped;
    p.padded_count    = n_padded;
    p.padding_total   = pad_sum;
    return p;
  endfunction

  // Random record: mostly well-formed application data, some noise.
  function automatic record_t random_record();
    record_t     r;
    int unsigned plen;
    int unsigned pick;
    r.func = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6) plen = $urandom_range(0, 2000);
    else if (pick < 8) plen = $urandom_range(0, 20000);
    else plen = $urandom_range(0, 65535);
    r.body_len  = plen[15:0];
    r.type_byte = ($urandom_range(0, 6) != 0) ? trpp_pkg::APP_DATA_TYPE
                                              : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (r.func == trpp_pkg::KIND_PLAINTEXT || pick == 0)
      r.total_len = 17'($urandom_range(0, 65540));
    else if (pick == 1) r.total_len = 17'($urandom_range(0, 4));
    else if (pick == 2)
      r.total_len = 17'(plen + trpp_pkg::HEADER_BYTES + $urandom_range(0, 2) - 1);
    else r.total_len = 17'(plen + trpp_pkg::HEADER_BYTES);
    pick = $urandom_range(0, 2);
    if (pick == 0) r.random_extra = 16'($urandom_range(0, 512));
    else if (pick == 1) r.random_extra = 16'($urandom_range(0, 65535));
    else r.random_extra = sh_min_extra + 16'($urandom_range(0, 64));
    return r;
  endfunction

  task automatic queue_record(logic f, int unsigned plen, int unsigned total,
                              int unsigned ctype, int unsigned draw);
    record_t r;
    r.func         = f;
    r.body_len     = plen[15:0];
    r.total_len    = total[16:0];
    r.type_byte    = ctype[7:0];
    r.random_extra = draw[15:0];
    record_q.insert(record_q.size(), r);
  endtask

  // One register write transaction; called at a rising edge.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    note_reg_write(idx, val);
  endtask

  task automatic load_setting(logic en, logic app, logic [2:0] strat, logic [15:0] maxs,
                              logic [15:0] blk, logic [15:0] minx, logic [15:0] maxx);
    write_reg(trpp_pkg::REG_ENABLE, {15'd0, en});
    write_reg(trpp_pkg::REG_APP_DATA_ONLY, {15'd0, app});
    write_reg(trpp_pkg::REG_STRATEGY, {13'd0, strat});
    write_reg(trpp_pkg::REG_MAX_SIZE, maxs);
    write_reg(trpp_pkg::REG_BLOCK_SIZE, blk);
    write_reg(trpp_pkg::REG_MIN_EXTRA, minx);
    write_reg(trpp_pkg::REG_MAX_EXTRA, maxx);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued record is in and every planned result is out.
  // The check runs on the falling edge, once the driver's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (record_q.size() != 0 || s_tvalid || planned_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Record source: presents queued records, plans each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      src_busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        planned_q.insert(planned_q.size(), plan_record(in_flight));
        src_busy = 1'b0;
      end
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          s_tvalid <= 1'b0;
        end else if (record_q.size() != 0) begin
          in_flight = record_q.pop_front();
          s_tdata  <= {7'd0, in_flight.random_extra, in_flight.type_byte,
                       in_flight.total_len, in_flight.body_len};
          s_tuser  <= in_flight.func;
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 17);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endtask

  // Result sink: stalls in bursts and checks each result transaction in order.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (planned_q.size() == 0) begin
          $error("result transaction with no record outstanding");
          err_count++;
        end else begin
          oldest_plan = planned_q.pop_front();
          check_field("status", 32'(oldest_plan.status), 32'(m_tuser));
          check_field("new_len", 32'(oldest_plan.new_len), 32'(m_tdata[16:0]));
          check_field("pad_bytes", 32'(oldest_plan.pad_bytes), 32'(m_tdata[32:17]));
          check_field("processed_count", oldest_plan.processed_count, m_tdata[64:33]);
          check_field("skipped_count", oldest_plan.skipped_count, m_tdata[96:65]);
          check_field("padded_count", oldest_plan.padded_count, m_tdata[128:97]);
          check_field("padding_total", oldest_plan.padding_total, m_tdata[160:129]);
        end
      end
      if (sink_gap > 0) begin
        sink_gap = sink_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 17);
      end
    end
  end

  // Stimulus: directed records, then random phases under changing settings.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: power-of-two buckets clamped at 16384.
    // The first plaintext record has no room for padding.
    queue_record(trpp_pkg::KIND_PLAINTEXT, 0, 0, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_PLAINTEXT, 100, 0, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_PLAINTEXT, 65535, 65540, trpp_pkg::APP_DATA_TYPE, 65535);
    queue_record(trpp_pkg::KIND_SEALED, 100, 105, trpp_pkg::APP_DATA_TYPE, 0);
    // Short record, length mismatch, and two records whose target is not larger.
    queue_record(trpp_pkg::KIND_SEALED, 0, 3, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_SEALED, 100, 106, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_SEALED, 16384, 16389, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_SEALED, 65535, 65540, trpp_pkg::APP_DATA_TYPE, 0);
    // Two records that are not application data, with an empty sealed record between them.
    queue_record(trpp_pkg::KIND_PLAINTEXT, 50, 0, 8'h16, 0);
    queue_record(trpp_pkg::KIND_SEALED, 0, 5, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_PLAINTEXT, 50, 131071, 8'hFF, 65535);
    wait_idle();

    load_setting(1'b1, 1'b1, trpp_pkg::STRAT_BLOCK, 16'd16384, 16'd256, 16'd0, 16'd255);
    queue_record(trpp_pkg::KIND_PLAINTEXT, 255, 0, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_SEALED, 1, 6, trpp_pkg::APP_DATA_TYPE, 0);
    wait_idle();

    // Zero block size leaves the size unchanged.
    load_setting(1'b1, 1'b1, trpp_pkg::STRAT_BLOCK, 16'd16384, 16'd0, 16'd0, 16'd255);
    queue_record(trpp_pkg::KIND_SEALED, 10, 15, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_PLAINTEXT, 10, 0, trpp_pkg::APP_DATA_TYPE, 0);
    wait_idle();

    // Random extra clamped into [10, 20].
    load_setting(1'b1, 1'b1, trpp_pkg::STRAT_RANDOM, 16'd16384, 16'd256, 16'd10, 16'd20);
    queue_record(trpp_pkg::KIND_PLAINTEXT, 30, 0, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_SEALED, 30, 35, trpp_pkg::APP_DATA_TYPE, 65535);
    queue_record(trpp_pkg::KIND_SEALED, 30, 35, trpp_pkg::APP_DATA_TYPE, 15);
    wait_idle();

    load_setting(1'b1, 1'b1, trpp_pkg::STRAT_CONST, 16'd16384, 16'd256, 16'd0, 16'd255);
    queue_record(trpp_pkg::KIND_SEALED, 0, 5, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_PLAINTEXT, 16383, 0, trpp_pkg::APP_DATA_TYPE, 0);
    wait_idle();

    // Constant target above the record limit.
    load_setting(1'b1, 1'b1, trpp_pkg::STRAT_CONST, 16'd65535, 16'd256, 16'd0, 16'd255);
    queue_record(trpp_pkg::KIND_SEALED, 100, 105, trpp_pkg::APP_DATA_TYPE, 0);
    wait_idle();

    load_setting(1'b1, 1'b1, STRAT_NONE, 16'd16384, 16'd256, 16'd0, 16'd255);
    queue_record(trpp_pkg::KIND_PLAINTEXT, 100, 0, trpp_pkg::APP_DATA_TYPE, 0);
    queue_record(trpp_pkg::KIND_SEALED, 100, 105, trpp_pkg::APP_DATA_TYPE, 0);
    wait_idle();

    load_setting(1'b0, 1'b1, trpp_pkg::STRAT_POW2, 16'd16384, 16'd256, 16'd0, 16'd255);
    queue_record(trpp_pkg::KIND_SEALED, 100, 105, trpp_pkg::APP_DATA_TYPE, 0);
    wait_idle();

    // Random phases.
    for (int p = 0; p < 16; p++) begin
      case (p)
        0:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_POW2, 16'd16384, 16'd256,
                         16'd0, 16'd255);
        1:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_BLOCK, 16'd16384, 16'd0,
                         16'd0, 16'd255);
        2:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_BLOCK, 16'd16384, 16'd1,
                         16'd0, 16'd255);
        3:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_BLOCK, 16'd65535, 16'd65535,
                         16'd0, 16'd255);
        4:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_BLOCK, 16'($urandom_range(0, 65535)),
                         16'($urandom_range(1, 4096)), 16'd0, 16'd255);
        5:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_RANDOM, 16'd16384, 16'd256,
                         16'd0, 16'd0);
        6:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_RANDOM, 16'd65535, 16'd256,
                         16'd65535, 16'd65535);
        7:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_RANDOM, 16'd16384, 16'd256,
                         16'd300, 16'd100);
        8:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_RANDOM, 16'($urandom_range(0, 65535)),
                         16'd256, 16'($urandom_range(0, 2000)),
                         16'($urandom_range(0, 65535)));
        9:  load_setting(1'b1, 1'b1, trpp_pkg::STRAT_CONST, 16'd0, 16'd256,
                         16'd0, 16'd255);
        10: load_setting(1'b1, 1'b1, trpp_pkg::STRAT_CONST, 16'($urandom_range(0, 20000)),
                         16'd256, 16'd0, 16'd255);
        11: load_setting(1'b1, 1'b1, STRAT_NONE, 16'd16384, 16'd256, 16'd0, 16'd255);
        12: load_setting(1'b1, 1'b1, STRAT_SPARE, 16'd16384, 16'd256, 16'd0, 16'd255);
        13: load_setting(1'b0, 1'b0, trpp_pkg::STRAT_POW2, 16'd16384, 16'd256,
                         16'd0, 16'd255);
        14: load_setting(1'b1, 1'b0, trpp_pkg::STRAT_POW2, 16'd65535, 16'd256,
                         16'd0, 16'd255);
        default: begin
          // The write past the register file must change nothing.
          calm = 1'b1;
          write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
          load_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       3'($urandom_range(0, 4)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 1000)),
                       16'($urandom_range(0, 65535)));
        end
      endcase
      repeat (52) record_q.insert(record_q.size(), random_record());
      wait_idle();
    end

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
sv/trpp_pkg.sv
sv/tls_record_padding_planner_unit.sv
sim/tb_tls_record_padding_planner_unit.sv
